// ===== sv/uvb_pkg.sv =====
// shared types, constants and status codes for the block stream validator
`default_nettype none
package uvb_pkg;

  localparam int PAGE_BYTES_DEF   = 256;
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int FLASH_BYTES_DEF  = 2097152;

  localparam logic [31:0] MAGIC_A      = 32'h0A32_4655;
  localparam logic [31:0] MAGIC_B      = 32'h9E5D_5157;
  localparam logic [31:0] MAGIC_Z      = 32'h0AB1_6F30;
  localparam int          FLAG_NOFLASH = 0;
  localparam int          FLAG_FAMILY  = 13;
  localparam logic [31:0] FAM_ARM_S    = 32'hE48B_FF59;
  localparam logic [31:0] FAM_RISCV    = 32'hE48B_FF60;
  localparam logic [31:0] FAM_ARM_NS   = 32'hE48B_FF61;
  localparam logic [31:0] MAX_PAYLOAD  = 32'd476;

  localparam logic [31:0] WINDOW_BASE_RST  = 32'h1000_0000;
  localparam logic [24:0] STAGING_OFS_RST  = 25'h010_0000;
  localparam logic [24:0] SETTINGS_OFS_RST = 25'h01F_F000;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW_BASE  = 2'd0;
  localparam logic [1:0] REG_STAGING_OFS  = 2'd1;
  localparam logic [1:0] REG_SETTINGS_OFS = 2'd2;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_MAGIC    = 4'd1;
  localparam logic [3:0] ST_SEQ      = 4'd2;
  localparam logic [3:0] ST_FAMILY   = 4'd3;
  localparam logic [3:0] ST_PAYLOAD  = 4'd4;
  localparam logic [3:0] ST_ADDR     = 4'd5;
  localparam logic [3:0] ST_COUNT    = 4'd6;
  localparam logic [3:0] ST_NODATA   = 4'd7;
  localparam logic [3:0] ST_NOORIGIN = 4'd8;

  typedef struct packed {
    logic        end_of_file;
    logic [31:0] magic_first;
    logic [31:0] magic_second;
    logic [31:0] magic_last;
    logic [31:0] flag_bits;
    logic [31:0] load_address;
    logic [31:0] payload_length;
    logic [31:0] seq_number;
    logic [31:0] total_count;
    logic [31:0] family_or_length;
  } in_item_t;

  typedef struct packed {
    logic        final_res;
    logic [3:0]  status;
    logic        mark_sector;
    logic [8:0]  erase_sector;
    logic [31:0] block_total;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic        eof;
    logic        magic_ok;
    logic        noflash;
    logic        fam_bad;
    logic        pay_bad;
    logic        addr_bad;
    logic        skip;
    logic        origin;
    logic        mark;
    logic [8:0]  sector;
    logic [31:0] seq;
    logic [31:0] total;
  } cls_t;

endpackage
`default_nettype wire

// ===== sv/uf2_block_stream_validator_unit.sv =====
// block stream validator: one result per header
// throughput one item per cycle unless the result stalls; the back end sets the pace
// an accepted item is written into the queue, then popped into the result register
// a two-entry queue takes items while a result is stalled, until the queue is full
// rst_n is synchronous: it clears all tracking state and loads the register defaults
`default_nettype none
module uf2_block_stream_validator_unit import uvb_pkg::*; #(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int FLASH_BYTES  = FLASH_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] window_base_r;
  logic [24:0] staging_ofs_r;
  logic [24:0] settings_ofs_r;
  cls_t        cls, q_head;
  logic        q_full, q_valid, q_pop, push;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_base_r  <= WINDOW_BASE_RST;
      staging_ofs_r  <= STAGING_OFS_RST;
      settings_ofs_r <= SETTINGS_OFS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_BASE:  window_base_r  <= cfg_data;
        REG_STAGING_OFS:  staging_ofs_r  <= cfg_data[24:0];
        REG_SETTINGS_OFS: settings_ofs_r <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  uvb_front #(
    .PAGE_BYTES  (PAGE_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES),
    .FLASH_BYTES (FLASH_BYTES)
  ) u_front (
    .item        (in_item),
    .window_base (window_base_r),
    .staging_ofs (staging_ofs_r),
    .settings_ofs(settings_ofs_r),
    .cls         (cls)
  );

  uvb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(cls),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_valid),
    .head     (q_head)
  );

  uvb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

// ===== sv/uvb_front.sv =====
// front end: stateless classification of one block header
`default_nettype none
module uvb_front import uvb_pkg::*; #(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int FLASH_BYTES  = FLASH_BYTES_DEF
) (
  input  wire in_item_t    item,
  input  wire logic [31:0] window_base,
  input  wire logic [24:0] staging_ofs,
  input  wire logic [24:0] settings_ofs,
  output cls_t             cls
);

  localparam int PG_W  = $clog2(PAGE_BYTES);
  localparam int SEC_W = $clog2(SECTOR_BYTES);
  localparam int NSEC  = FLASH_BYTES / SECTOR_BYTES;

  logic [32:0] diff;
  logic [31:0] off0;
  logic [25:0] off1;
  logic [26:0] end_ofs;
  logic [25:0] idx;
  logic        in_flash;
  logic [31:0] fam;

  assign diff    = {1'b0, item.load_address} - {1'b0, window_base};
  assign off0    = diff[31:0];
  // only meaningful once off0 is below the staging offset
  assign off1    = {1'b0, off0[24:0]} + {1'b0, staging_ofs};
  assign end_ofs = {1'b0, off1} + {18'd0, item.payload_length[8:0]};
  assign idx     = off1 >> SEC_W;
  assign in_flash = idx < 26'(NSEC);
  assign fam     = item.family_or_length;

  always_comb begin
    cls.eof      = item.end_of_file;
    cls.magic_ok = (item.magic_first == MAGIC_A) && (item.magic_second == MAGIC_B) &&
                   (item.magic_last == MAGIC_Z);
    cls.noflash  = item.flag_bits[FLAG_NOFLASH];
    cls.fam_bad  = item.flag_bits[FLAG_FAMILY] &&
                   !((fam == FAM_ARM_S) || (fam == FAM_RISCV) || (fam == FAM_ARM_NS));
    cls.pay_bad  = (item.payload_length == 32'd0) || (item.payload_length > MAX_PAYLOAD) ||
                   (item.payload_length[PG_W-1:0] != '0);
    cls.addr_bad = diff[32] || (off0 >= {7'd0, staging_ofs});
    cls.skip     = end_ofs > {2'd0, settings_ofs};
    cls.origin   = off0 == 32'd0;
    cls.mark     = in_flash;
    cls.sector   = in_flash ? idx[8:0] : 9'd0;
    cls.seq      = item.seq_number;
    cls.total    = item.total_count;
  end

endmodule
`default_nettype wire

// ===== sv/uvb_queue.sv =====
// two-entry queue of classified items between front and back
`default_nettype none
module uvb_queue import uvb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cls_t push_data,
  input  wire logic pop,
  output logic      full,
  output logic      not_empty,
  output cls_t      head
);

  cls_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== sv/uvb_back.sv =====
// back end: sequence, total and sticky error tracking, result register
`default_nettype none
module uvb_back import uvb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire cls_t q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_item
);

  logic [31:0] next_seq_r, next_seq_nxt;
  logic [31:0] agreed_r, agreed_nxt;
  logic        origin_r, origin_nxt;
  logic        any_data_r, any_data_nxt;
  logic [3:0]  sticky_r, sticky_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, res;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    next_seq_nxt = next_seq_r;
    agreed_nxt   = agreed_r;
    origin_nxt   = origin_r;
    any_data_nxt = any_data_r;
    sticky_nxt   = sticky_r;
    res          = '0;

    if (q_head.eof) begin
      res.final_res = 1'b1;
      if (sticky_r != ST_OK) begin
        res.status = sticky_r;
      end else if (!any_data_r) begin
        res.status = ST_NODATA;
      end else if (!origin_r) begin
        res.status = ST_NOORIGIN;
      end else begin
        res.status      = ST_OK;
        res.block_total = agreed_r;
      end
      next_seq_nxt = 32'd0;
      agreed_nxt   = 32'd0;
      origin_nxt   = 1'b0;
      any_data_nxt = 1'b0;
      sticky_nxt   = ST_OK;
    end else if (sticky_r != ST_OK) begin
      res.status = sticky_r;
    end else begin
      if (!q_head.magic_ok) begin
        res.status = ST_MAGIC;
      end else if (q_head.seq != next_seq_r) begin
        res.status = ST_SEQ;
      end else begin
        next_seq_nxt = next_seq_r + 32'd1;
        if (q_head.noflash) begin
          res.status = ST_OK;
        end else if (q_head.fam_bad) begin
          res.status = ST_FAMILY;
        end else if (q_head.pay_bad) begin
          res.status = ST_PAYLOAD;
        end else if (q_head.addr_bad) begin
          res.status = ST_ADDR;
        end else if (q_head.skip) begin
          res.status = ST_OK;
        end else begin
          any_data_nxt = 1'b1;
          if (q_head.origin) begin
            origin_nxt = 1'b1;
          end
          if (agreed_r == 32'd0) begin
            agreed_nxt       = q_head.total;
            res.status       = ST_OK;
            res.mark_sector  = q_head.mark;
            res.erase_sector = q_head.sector;
          end else if (q_head.total != agreed_r) begin
            res.status = ST_COUNT;
          end else begin
            res.status       = ST_OK;
            res.mark_sector  = q_head.mark;
            res.erase_sector = q_head.sector;
          end
        end
      end
      sticky_nxt = res.status;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_seq_r  <= 32'd0;
      agreed_r    <= 32'd0;
      origin_r    <= 1'b0;
      any_data_r  <= 1'b0;
      sticky_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        next_seq_r <= next_seq_nxt;
        agreed_r   <= agreed_nxt;
        origin_r   <= origin_nxt;
        any_data_r <= any_data_nxt;
        sticky_r   <= sticky_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= res;
    end
  end

endmodule
`default_nettype wire

// ===== sim/uvb_result_check.sv =====
// result checker for the block stream validator: predicts every result and compares it
`timescale 1ns / 100ps
module uvb_result_check import uvb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          pending,
  output int          mismatches,
  output int          marks_seen,
  output logic [15:0] statuses_seen
);

  logic [31:0] window_base;
  logic [24:0] staging_ofs;
  logic [24:0] settings_ofs;

  logic [31:0] next_seq;
  logic [31:0] agreed_total;
  logic        origin_hit;
  logic        data_seen;
  logic [3:0]  held_error;

  out_item_t   results_due[$];
  out_item_t   due;
  int          fault_total = 0;
  int          mark_total = 0;
  logic [15:0] status_mask = '0;

  function automatic out_item_t judge_header(input in_item_t h);
    out_item_t   r;
    logic [3:0]  st;
    logic [31:0] ofs0;
    logic [63:0] staged;
    logic [63:0] sect;
    r = '0;
    if (h.end_of_file) begin
      r.final_res = 1'b1;
      if (held_error != ST_OK) r.status = held_error;
      else if (!data_seen) r.status = ST_NODATA;
      else if (!origin_hit) r.status = ST_NOORIGIN;
      else begin
        r.status = ST_OK;
        r.block_total = agreed_total;
      end
      next_seq = '0;
      agreed_total = '0;
      origin_hit = 1'b0;
      data_seen = 1'b0;
      held_error = ST_OK;
    end else if (held_error != ST_OK) begin
      // sticky error: item ignored, error repeated
      r.status = held_error;
    end else begin
      st = ST_OK;
      if (h.magic_first != MAGIC_A || h.magic_second != MAGIC_B || h.magic_last != MAGIC_Z)
        st = ST_MAGIC;
      else if (h.seq_number != next_seq)
        st = ST_SEQ;
      else begin
        next_seq = next_seq + 32'd1;
        if (h.flag_bits[FLAG_NOFLASH])
          st = ST_OK;
        else if (h.flag_bits[FLAG_FAMILY] && h.family_or_length != FAM_ARM_S &&
                 h.family_or_length != FAM_RISCV && h.family_or_length != FAM_ARM_NS)
          st = ST_FAMILY;
        else if (h.payload_length == '0 || h.payload_length > MAX_PAYLOAD ||
                 h.payload_length % PAGE_BYTES_DEF != 0)
          st = ST_PAYLOAD;
        else if (h.load_address < window_base)
          st = ST_ADDR;
        else begin
          ofs0 = h.load_address - window_base;
          staged = 64'(ofs0) + 64'(staging_ofs);
          if (ofs0 >= 32'(staging_ofs))
            st = ST_ADDR;
          else if (staged + 64'(h.payload_length) > 64'(settings_ofs))
            st = ST_OK; // would touch the settings page: dropped quietly
          else begin
            data_seen = 1'b1;
            if (ofs0 == '0) origin_hit = 1'b1;
            sect = staged / SECTOR_BYTES_DEF;
            if (sect < FLASH_BYTES_DEF / SECTOR_BYTES_DEF) begin
              r.mark_sector = 1'b1;
              r.erase_sector = sect[8:0];
            end
            if (agreed_total == '0)
              agreed_total = h.total_count;
            else if (h.total_count != agreed_total) begin
              r.mark_sector = 1'b0;
              r.erase_sector = '0;
              st = ST_COUNT;
            end
          end
        end
      end
      r.status = st;
      held_error = st;
    end
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      fault_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      window_base = WINDOW_BASE_RST;
      staging_ofs = STAGING_OFS_RST;
      settings_ofs = SETTINGS_OFS_RST;
      next_seq = '0;
      agreed_total = '0;
      origin_hit = 1'b0;
      data_seen = 1'b0;
      held_error = ST_OK;
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_BASE:  window_base = cfg_data;
          REG_STAGING_OFS:  staging_ofs = cfg_data[24:0];
          REG_SETTINGS_OFS: settings_ofs = cfg_data[24:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        results_due.push_back(judge_header(in_item));
      if (out_valid && !out_stall) begin
        status_mask[out_item.status] = 1'b1;
        if (out_item.mark_sector) mark_total++;
        if (results_due.size() == 0) begin
          $display("%0t: result expected none got %p", $time, out_item);
          fault_total++;
        end else begin
          due = results_due.pop_front();
          compare_field("final_res", 32'(due.final_res), 32'(out_item.final_res));
          compare_field("status", 32'(due.status), 32'(out_item.status));
          compare_field("mark_sector", 32'(due.mark_sector), 32'(out_item.mark_sector));
          compare_field("erase_sector", 32'(due.erase_sector), 32'(out_item.erase_sector));
          compare_field("block_total", due.block_total, out_item.block_total);
        end
      end
    end
    pending <= results_due.size();
    mismatches <= fault_total;
    marks_seen <= mark_total;
    statuses_seen <= status_mask;
  end

endmodule

// ===== sim/tb_uf2_block_stream_validator_unit.sv =====
// testbench top for the block stream validator: stimulus, register writes and verdict
`timescale 1ns / 100ps
module tb_uf2_block_stream_validator_unit;
  import uvb_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_WINDOW_BASE;
  logic [31:0] cfg_data = '0;

  int          pending;
  int          mismatches;
  int          marks_seen;
  logic [15:0] statuses_seen;

  int          quiet_cycles = 0;
  int          holds_asked = 0;
  int          holds_served = 0;
  bit          sender_calm = 1'b0;
  int          items_sent = 0;
  int          verdicts_asked = 0;
  int          settings_used = 1;
  logic [31:0] shape_base = WINDOW_BASE_RST;
  logic [31:0] shape_staging = 32'(STAGING_OFS_RST);

  always #1 clk = ~clk;

  uf2_block_stream_validator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  uvb_result_check result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (pending),
    .mismatches    (mismatches),
    .marks_seen    (marks_seen),
    .statuses_seen (statuses_seen)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_item_t clean_block(input logic [31:0] seq, input logic [31:0] ofs,
                                           input logic [31:0] total);
    in_item_t h;
    h = '0;
    h.magic_first = MAGIC_A;
    h.magic_second = MAGIC_B;
    h.magic_last = MAGIC_Z;
    h.flag_bits[FLAG_FAMILY] = 1'b1;
    h.family_or_length = FAM_ARM_S;
    h.load_address = shape_base + ofs;
    h.payload_length = 32'(PAGE_BYTES_DEF);
    h.seq_number = seq;
    h.total_count = total;
    return h;
  endfunction

  function automatic in_item_t stray_header();
    in_item_t h;
    h.end_of_file = ($urandom_range(0, 3) == 0);
    h.magic_first = $urandom();
    h.magic_second = $urandom();
    h.magic_last = $urandom();
    h.flag_bits = $urandom();
    h.load_address = $urandom();
    h.payload_length = $urandom();
    h.seq_number = $urandom();
    h.total_count = $urandom();
    h.family_or_length = $urandom();
    return h;
  endfunction

  function automatic in_item_t verdict_request();
    in_item_t h;
    h = stray_header();
    h.end_of_file = 1'b1;
    return h;
  endfunction

  // well-formed block with random content, sometimes broken in one field
  function automatic in_item_t file_block(input logic [31:0] seq, input logic [31:0] total,
                                          input bit origin);
    in_item_t    h;
    int unsigned pages;
    logic [31:0] ofs;
    logic [31:0] flip;
    pages = shape_staging >> 8;
    if (origin || pages == 0)
      ofs = '0;
    else if ($urandom_range(0, 7) == 0)
      ofs = (pages - $urandom_range(1, pages < 16 ? pages : 16)) << 8;
    else
      ofs = $urandom_range(0, pages - 1) << 8;
    if (!origin && pages != 0 && $urandom_range(0, 7) == 0)
      ofs[7:0] = 8'($urandom_range(1, 255));
    h = clean_block(seq, ofs, total);
    if ($urandom_range(0, 3) == 0) h.flag_bits = $urandom();
    h.flag_bits[FLAG_NOFLASH] = ($urandom_range(0, 7) == 0);
    h.flag_bits[FLAG_FAMILY] = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 2))
      0: h.family_or_length = FAM_ARM_S;
      1: h.family_or_length = FAM_RISCV;
      default: h.family_or_length = FAM_ARM_NS;
    endcase
    if (!h.flag_bits[FLAG_FAMILY]) h.family_or_length = $urandom();
    if ($urandom_range(0, 15) == 0) begin
      flip = 32'd1 << $urandom_range(0, 31);
      h.flag_bits[FLAG_NOFLASH] = 1'b0;
      case ($urandom_range(0, 5))
        0: begin
          case ($urandom_range(0, 2))
            0: h.magic_first ^= flip;
            1: h.magic_second ^= flip;
            default: h.magic_last ^= flip;
          endcase
        end
        1: h.seq_number = seq ^ flip;
        2: begin
          h.flag_bits[FLAG_FAMILY] = 1'b1;
          h.family_or_length = $urandom();
        end
        3: begin
          case ($urandom_range(0, 4))
            0: h.payload_length = '0;
            1: h.payload_length = MAX_PAYLOAD;
            2: h.payload_length = 32'd512;
            3: h.payload_length = 32'd255;
            default: h.payload_length = $urandom();
          endcase
        end
        4: begin
          if ($urandom_range(0, 1) == 0)
            h.load_address = shape_base - 32'd1 - ($urandom() & 32'h0000_FFFF);
          else
            h.load_address = shape_base + shape_staging + ($urandom() & 32'h0000_FFFF);
        end
        default: h.total_count = total ^ flip;
      endcase
    end
    return h;
  endfunction

  task automatic offer_header(input in_item_t h);
    int unsigned gap;
    in_item <= h;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (h.end_of_file) verdicts_asked++;
    gap = sender_calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_files(input int files);
    int unsigned len;
    logic [31:0] total;
    bit          origin;
    for (int f = 0; f < files; f++) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) offer_header(stray_header());
      end else begin
        len = $urandom_range(1, 8);
        case ($urandom_range(0, 9))
          0: total = '0;
          1: total = $urandom();
          default: total = len;
        endcase
        origin = ($urandom_range(0, 3) != 0);
        for (int b = 0; b < len; b++)
          offer_header(file_block(b, total, origin && b == 0));
        offer_header(verdict_request());
      end
    end
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [31:0] base, input logic [31:0] staging,
                            input logic [31:0] settings);
    write_reg(REG_WINDOW_BASE, base);
    write_reg(REG_STAGING_OFS, staging);
    write_reg(REG_SETTINGS_OFS, settings);
    shape_base = base;
    shape_staging = staging;
    settings_used++;
  endtask

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    @(posedge clk);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // result side back-pressure
  initial begin
    int unsigned span;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_served != holds_asked) begin
        // long hold-off so the block fills and stalls its input
        holds_served = holds_asked;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 15) == 0) begin
        repeat (40) @(posedge clk);
      end else begin
        span = idle_len();
        if (span != 0) begin
          out_stall <= 1'b1;
          repeat (span) @(posedge clk);
          out_stall <= 1'b0;
        end
        @(posedge clk);
      end
    end
  end

  initial begin
    in_item_t    h;
    logic [31:0] stage_pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_header(verdict_request());
    offer_header(clean_block(0, 0, 3));
    h = clean_block(1, 32'h0000_FF00, 3);
    h.flag_bits[FLAG_NOFLASH] = 1'b1;
    h.payload_length = '0;
    offer_header(h);
    h = clean_block(2, 32'h0001_FF00, 3);
    h.family_or_length = FAM_RISCV;
    offer_header(h);
    // staged end runs into the settings page
    h = clean_block(3, 32'h000F_FF00, 3);
    h.family_or_length = FAM_ARM_NS;
    offer_header(h);
    offer_header(verdict_request());
    offer_header(clean_block(0, 32'h0000_0100, 5));
    offer_header(verdict_request());
    h = clean_block(0, 0, 1);
    h.magic_second ^= 32'h0000_0080;
    offer_header(h);
    offer_header(clean_block(1, 0, 1));
    offer_header(verdict_request());
    offer_header(clean_block(4, 0, 1));
    offer_header(verdict_request());
    h = clean_block(0, 0, 1);
    h.family_or_length = FAM_ARM_S - 32'd1;
    offer_header(h);
    offer_header(verdict_request());
    h = clean_block(0, 0, 1);
    h.payload_length = MAX_PAYLOAD;
    offer_header(h);
    offer_header(verdict_request());
    offer_header(clean_block(0, 32'(STAGING_OFS_RST), 1));
    offer_header(verdict_request());
    offer_header(clean_block(0, 0, 2));
    offer_header(clean_block(1, 32'h0000_1000, 7));
    offer_header(verdict_request());
    // zero total is replaced by the next data block's count
    h = clean_block(0, 0, 0);
    h.flag_bits = '0;
    h.family_or_length = 32'hFFFF_FFFF;
    offer_header(h);
    offer_header(clean_block(1, 32'h0000_2000, 9));
    offer_header(verdict_request());

    sender_calm = 1'b1;
    holds_asked++;
    run_files(3);
    sender_calm = 1'b0;
    run_files(40);

    // staging bank reaches past the end of flash
    drain();
    set_window(32'h0000_0000, 32'h0018_0000, 32'h0100_0000);
    run_files(20);

    drain();
    set_window(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    run_files(4);

    // every data block lands on the settings page
    drain();
    set_window(32'h2000_0000, 32'h0100_0000, 32'h0100_0000);
    run_files(4);

    drain();
    stage_pick = $urandom_range(32'h0000_1000, 32'h0010_0000);
    set_window($urandom() & 32'hFF00_0000, stage_pick,
               $urandom_range(stage_pick, 32'h0100_0000));
    run_files(15);

    drain();
    set_window(WINDOW_BASE_RST, 32'(STAGING_OFS_RST), 32'(SETTINGS_OFS_RST));
    run_files(5);
    drain();

    $display("run covered %0d items, %0d of them end-of-file, over %0d register settings",
             items_sent, verdicts_asked, settings_used);
    $display("status codes returned (bit per code) %b, staging sectors marked %0d",
             statuses_seen[8:0], marks_seen);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
